[rtl/cgv_pkg.sv]
// ----------------------------------------------------------------------------
// cgv_pkg
// Shared widths, stream word layout, opcodes and controller commands for the
// coalition graph value block.
// ----------------------------------------------------------------------------
package cgv_pkg;

  localparam int OP_W    = 2;
  localparam int AGENT_W = 4;
  localparam int SLOT_W  = 7;
  localparam int DATA_W  = 32;
  localparam int MASK_W  = 16;
  localparam int TOTAL_W = 40;

  // Bit positions of the input fields inside the input word.
  localparam int OP_LSB   = 0;
  localparam int HI_LSB   = OP_LSB + OP_W;
  localparam int LO_LSB   = HI_LSB + AGENT_W;
  localparam int SLOT_LSB = LO_LSB + AGENT_W;
  localparam int DATA_LSB = SLOT_LSB + SLOT_W;
  localparam int MASK_LSB = DATA_LSB + DATA_W;
  localparam int IN_FIELDS_W = MASK_LSB + MASK_W;

  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TOTAL_W + 7) / 8) * 8;

  localparam int DEF_AGENTS     = 16;
  localparam int DEF_EDGE_SLOTS = 128;

  typedef enum logic [OP_W-1:0] {
    OP_WR_VALUE  = 2'd0,
    OP_WR_MAP    = 2'd1,
    OP_WR_WEIGHT = 2'd2,
    OP_EVAL      = 2'd3
  } cgv_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_value;
    logic wr_map;
    logic wr_weight;
    logic start;
    logic issue;
    logic issue_val;
    logic load_out;
  } cgv_cmd_t;

  function automatic logic [TOTAL_W-1:0] sext_total(input logic [DATA_W-1:0] x);
    return {{(TOTAL_W - DATA_W){x[DATA_W-1]}}, x};
  endfunction

endpackage

[rtl/coalition_graph_value.sv]
// ----------------------------------------------------------------------------
// coalition_graph_value
// Sum of member values and internal edge weights of a coalition of agents.
// ----------------------------------------------------------------------------
// Input words carry an opcode. Opcode 0 writes an agent value, 1 writes the
// edge slot for an agent pair (higher agent first), 2 writes an edge weight,
// and 3 evaluates the coalition given by member_mask. A write produces no
// output word; writes that name an agent or slot outside the tables are
// dropped. An evaluation produces exactly one output word: the 40-bit signed
// sum of the values of all members plus the weight of every member pair
// (hi > lo) through the pair map; a pair whose map entry lies beyond the
// weight table adds nothing. The evaluation walks every agent once and every
// pair with hi > lo once, one table lookup per cycle, then drains the read
// pipeline and loads the result once the output register is free; in_tready
// is low throughout. The walk is bound by the chained reads of the pair map
// and then the weight memory, one pair per cycle. The result waits in an
// output register, so new words are taken while it is still pending. Tables
// are not cleared by reset and must be written before they are read.
// ----------------------------------------------------------------------------
module coalition_graph_value #(
  parameter int AGENTS     = cgv_pkg::DEF_AGENTS,
  parameter int EDGE_SLOTS = cgv_pkg::DEF_EDGE_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0 up: opcode, agent_hi, agent_lo, edge_slot, load_data,
  // member_mask, zero fill.
  input  logic [cgv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0 up: coalition_total.
  output logic [cgv_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import cgv_pkg::*;

  localparam int AW = $clog2(AGENTS);

  cgv_cmd_t                  cmd;
  logic [AW-1:0]             issue_hi;
  logic [AW-1:0]             issue_lo;
  cgv_op_t                   in_op;
  logic signed [TOTAL_W-1:0] coalition_total;

  // Unpack the input word.
  assign in_op = cgv_op_t'(in_tdata[OP_LSB +: OP_W]);

  cgv_ctrl #(
    .AGENTS (AGENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .issue_hi   (issue_hi),
    .issue_lo   (issue_lo)
  );

  cgv_datapath #(
    .AGENTS     (AGENTS),
    .EDGE_SLOTS (EDGE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .issue_hi    (issue_hi),
    .issue_lo    (issue_lo),
    .agent_hi    (in_tdata[HI_LSB +: AGENT_W]),
    .agent_lo    (in_tdata[LO_LSB +: AGENT_W]),
    .edge_slot   (in_tdata[SLOT_LSB +: SLOT_W]),
    .load_data   (in_tdata[DATA_LSB +: DATA_W]),
    .member_mask (in_tdata[MASK_LSB +: MASK_W]),
    .out_total   (coalition_total)
  );

  assign out_tdata = OUT_TDATA_W'(unsigned'(coalition_total));

endmodule

[rtl/cgv_ctrl.sv]
// ----------------------------------------------------------------------------
// cgv_ctrl
// Controller: decodes input words, walks agents and agent pairs for an
// evaluation, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cgv_ctrl #(
  parameter int AGENTS = cgv_pkg::DEF_AGENTS,
  localparam int AW = $clog2(AGENTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cgv_pkg::cgv_op_t  in_op,
  output logic              out_tvalid,
  input  logic              out_tready,
  output cgv_pkg::cgv_cmd_t cmd,
  output logic [AW-1:0]     issue_hi,
  output logic [AW-1:0]     issue_lo
);
  import cgv_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_VAL, S_PAIR, S_DRAIN, S_DONE} state_t;

  localparam logic [AW-1:0] LAST_AGENT = AW'(AGENTS - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic          drain_r, drain_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign issue_hi   = hi_r;
  assign issue_lo   = lo_r;

  always_comb begin
    state_nxt = state_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    drain_nxt = drain_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_WR_VALUE:  cmd.wr_value  = 1'b1;
            OP_WR_MAP:    cmd.wr_map    = 1'b1;
            OP_WR_WEIGHT: cmd.wr_weight = 1'b1;
            OP_EVAL: begin
              cmd.start = 1'b1;
              hi_nxt    = '0;
              lo_nxt    = '0;
              state_nxt = S_VAL;
            end
            default: ;
          endcase
        end
      end
      S_VAL: begin
        // Value step of agent hi, then its pairs with every lower agent.
        cmd.issue     = 1'b1;
        cmd.issue_val = 1'b1;
        if (hi_r == '0) begin
          hi_nxt = AW'(hi_r + 1'b1);
        end else begin
          lo_nxt    = '0;
          state_nxt = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd.issue = 1'b1;
        if (lo_r == AW'(hi_r - 1'b1)) begin
          if (hi_r == LAST_AGENT) begin
            drain_nxt = 1'b0;
            state_nxt = S_DRAIN;
          end else begin
            hi_nxt    = AW'(hi_r + 1'b1);
            state_nxt = S_VAL;
          end
        end else begin
          lo_nxt = AW'(lo_r + 1'b1);
        end
      end
      S_DRAIN: begin
        if (drain_r) begin
          state_nxt = S_DONE;
        end else begin
          drain_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hi_r        <= '0;
      lo_r        <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/cgv_datapath.sv]
// ----------------------------------------------------------------------------
// cgv_datapath
// Table memories, a three-stage read pipeline (value and pair map, edge
// weight, accumulate) and the result register.
// ----------------------------------------------------------------------------
module cgv_datapath #(
  parameter int AGENTS     = cgv_pkg::DEF_AGENTS,
  parameter int EDGE_SLOTS = cgv_pkg::DEF_EDGE_SLOTS,
  localparam int AW = $clog2(AGENTS),
  localparam int SW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1,
  localparam int PW = 2 * AW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cgv_pkg::cgv_cmd_t              cmd,
  input  logic [AW-1:0]                  issue_hi,
  input  logic [AW-1:0]                  issue_lo,
  input  logic [cgv_pkg::AGENT_W-1:0]    agent_hi,
  input  logic [cgv_pkg::AGENT_W-1:0]    agent_lo,
  input  logic [cgv_pkg::SLOT_W-1:0]     edge_slot,
  input  logic signed [cgv_pkg::DATA_W-1:0] load_data,
  input  logic [cgv_pkg::MASK_W-1:0]     member_mask,
  output logic signed [cgv_pkg::TOTAL_W-1:0] out_total
);
  import cgv_pkg::*;

  logic [DATA_W-1:0] value_mem  [AGENTS];
  logic [SLOT_W-1:0] map_mem    [2**PW];
  logic [DATA_W-1:0] weight_mem [EDGE_SLOTS];

  logic               hi_ok, lo_ok, wslot_ok;
  logic [AGENTS-1:0]  mask_r;
  logic               hit;

  // Stage 1: agent value and pair map read.
  logic               s1_valid_r, s1_val_r, s1_hit_r;
  logic [DATA_W-1:0]  s1_value_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  // Stage 2: edge weight read.
  logic               s2_valid_r, s2_val_r, s2_hit_r, s2_slot_ok_r;
  logic [DATA_W-1:0]  s2_value_r;
  logic [DATA_W-1:0]  s2_weight_r;
  logic [DATA_W-1:0]  addend;
  logic [TOTAL_W-1:0] acc_r;
  logic [TOTAL_W-1:0] total_r;

  assign hi_ok    = int'(agent_hi) < AGENTS;
  assign lo_ok    = int'(agent_lo) < AGENTS;
  assign wslot_ok = int'(edge_slot) < EDGE_SLOTS;

  // A pair counts only when both agents are members; a value step needs hi only.
  assign hit = mask_r[issue_hi] && (cmd.issue_val || mask_r[issue_lo]);

  always_ff @(posedge clk) begin
    if (cmd.wr_value && hi_ok) begin
      value_mem[AW'(agent_hi)] <= load_data;
    end
    if (cmd.wr_map && hi_ok && lo_ok) begin
      map_mem[{AW'(agent_hi), AW'(agent_lo)}] <= edge_slot;
    end
    if (cmd.wr_weight && wslot_ok) begin
      weight_mem[SW'(edge_slot)] <= load_data;
    end
    s1_value_r  <= value_mem[issue_hi];
    s1_slot_r   <= map_mem[{issue_hi, issue_lo}];
    s2_weight_r <= weight_mem[SW'(s1_slot_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask_r <= AGENTS'(member_mask);
    end
    s1_val_r     <= cmd.issue_val;
    s1_hit_r     <= hit;
    s2_val_r     <= s1_val_r;
    s2_hit_r     <= s1_hit_r;
    s2_value_r   <= s1_value_r;
    s2_slot_ok_r <= int'(s1_slot_r) < EDGE_SLOTS;
    if (cmd.load_out) begin
      total_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  // A map entry naming a slot beyond the weight table adds nothing.
  always_comb begin
    if (s2_val_r) begin
      addend = s2_value_r;
    end else if (s2_slot_ok_r) begin
      addend = s2_weight_r;
    end else begin
      addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (s2_valid_r && s2_hit_r) begin
      acc_r <= acc_r + sext_total(addend);
    end
  end

  assign out_total = total_r;

endmodule

[rtl/cgv_checker.sv]
// ----------------------------------------------------------------------------
// cgv_checker
// Port-level checks of the coalition graph value block, bound to its top.
// ----------------------------------------------------------------------------
module cgv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [cgv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cgv_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cgv_pkg::*;

  logic is_eval;

  assign is_eval = (cgv_op_t'(in_tdata[OP_LSB +: OP_W]) == OP_EVAL);

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");

  // A table write leaves the block ready again in the next cycle.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !is_eval |=> in_tready)
    else $error("block not ready after a table write");

  // An evaluation occupies the block for its walk.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && is_eval |=> !in_tready)
    else $error("block ready right after an evaluate word");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed or dropped");

endmodule

bind coalition_graph_value cgv_checker u_cgv_checker (.*);

[tb/coalition_graph_value_checker.sv]
// ----------------------------------------------------------------------------
// coalition_graph_value_checker
// Watches both streams of the coalition graph value block. It keeps its own
// copy of the three tables, works out the coalition total for every evaluate
// word it sees accepted, and compares each accepted output word with the
// oldest total still due.
// ----------------------------------------------------------------------------
module coalition_graph_value_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [cgv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cgv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int unsigned                     errors,
  output int unsigned                     pending,
  output int unsigned                     totals_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import cgv_pkg::*;

  // Input word seen field by field, the first field in the lowest bits.
  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELDS_W-1:0] fill;
    logic [MASK_W-1:0]                 member_mask;
    logic signed [DATA_W-1:0]          load_data;
    logic [SLOT_W-1:0]                 edge_slot;
    logic [AGENT_W-1:0]                agent_lo;
    logic [AGENT_W-1:0]                agent_hi;
    cgv_op_t                           opcode;
  } cgv_word_t;

  logic signed [DATA_W-1:0] member_value [DEF_AGENTS];
  logic [SLOT_W-1:0]        slot_of_pair [DEF_AGENTS*DEF_AGENTS];
  logic signed [DATA_W-1:0] slot_weight  [DEF_EDGE_SLOTS];

  logic signed [TOTAL_W-1:0] totals_due [$];
  int unsigned err_count;
  int unsigned checked_count;

  initial begin
    foreach (member_value[i]) member_value[i] = '0;
    foreach (slot_of_pair[i]) slot_of_pair[i] = '0;
    foreach (slot_weight[i]) slot_weight[i] = '0;
  end

  // Member values plus the weight behind every member pair, higher agent
  // first. A pair that maps beyond the weight table adds nothing.
  function automatic logic signed [TOTAL_W-1:0] coalition_sum(
    input logic [MASK_W-1:0] members
  );
    logic signed [TOTAL_W-1:0] acc;
    logic [SLOT_W-1:0] s;
    acc = '0;
    for (int a = 0; a < DEF_AGENTS && a < MASK_W; a++) begin
      if (members[a]) begin
        acc = acc + TOTAL_W'(member_value[a]);
        for (int b = 0; b < a; b++) begin
          if (members[b]) begin
            s = slot_of_pair[a*DEF_AGENTS + b];
            if (s < DEF_EDGE_SLOTS) acc = acc + TOTAL_W'(slot_weight[s]);
          end
        end
      end
    end
    return acc;
  endfunction

  function automatic void apply_word(input cgv_word_t w);
    case (w.opcode)
      OP_WR_VALUE: begin
        if (w.agent_hi < DEF_AGENTS) member_value[w.agent_hi] = w.load_data;
      end
      OP_WR_MAP: begin
        if (w.agent_hi < DEF_AGENTS && w.agent_lo < DEF_AGENTS)
          slot_of_pair[w.agent_hi*DEF_AGENTS + w.agent_lo] = w.edge_slot;
      end
      OP_WR_WEIGHT: begin
        if (w.edge_slot < DEF_EDGE_SLOTS) slot_weight[w.edge_slot] = w.load_data;
      end
      default: totals_due.push_back(coalition_sum(w.member_mask));
    endcase
  endfunction

  function automatic void check_total(input logic signed [TOTAL_W-1:0] got);
    logic signed [TOTAL_W-1:0] want;
    if (totals_due.size() == 0) begin
      err_count++;
      $display("%t: output word with no evaluation pending, actual %0d", $time, got);
    end else begin
      want = totals_due.pop_front();
      checked_count++;
      if (got !== want) begin
        err_count++;
        $display("%t: coalition_total mismatch, expected %0d, actual %0d",
                 $time, want, got);
      end
    end
  endfunction

  // The output side is looked at first, so a result can never be matched
  // against an evaluation accepted on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      totals_due.delete();
      err_count = 0;
      checked_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_total(out_tdata[TOTAL_W-1:0]);
      if (in_tvalid && in_tready) apply_word(cgv_word_t'(in_tdata));
    end
    errors         <= err_count;
    totals_checked <= checked_count;
    pending        <= totals_due.size();
  end

endmodule

[tb/coalition_graph_value_tb.sv]
// ----------------------------------------------------------------------------
// coalition_graph_value_tb
// Stimulus and verdict for the coalition graph value block. Table writes and
// evaluate words are streamed in under several idle and stall mixes, and the
// checker beside the block predicts and compares every coalition total.
// ----------------------------------------------------------------------------
module coalition_graph_value_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgv_pkg::*;

  localparam int          CLK_PERIOD_NS = 20;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_WORDS  = 1580;
  // Long enough for one full evaluation walk, with margin.
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned LIMIT_CYCLES  = 4_000_000;
  localparam int          PAIRS         = DEF_AGENTS * DEF_AGENTS;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // Fields from bit 0 up: opcode, agent_hi, agent_lo, edge_slot, load_data,
  // member_mask, zero fill.
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // Fields from bit 0 up: coalition_total.
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned totals_checked;

  // Idle and stall odds in percent, changed from phase to phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Flipping this asks the receiver for one long hold-off.
  bit          hold_toggle    = 1'b0;

  // Which table entries have been written so far. An evaluation is only sent
  // once every entry it will read holds a value.
  bit                value_ok  [DEF_AGENTS];
  bit                map_ok    [PAIRS];
  logic [SLOT_W-1:0] map_slot  [PAIRS];
  bit                weight_ok [DEF_EDGE_SLOTS];

  int unsigned words_sent;
  int unsigned words_by_op [4];

  coalition_graph_value u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  coalition_graph_value_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .errors         (errors),
    .pending        (pending),
    .totals_checked (totals_checked)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD_NS / 2);
    clk = 1'b1;
    #(CLK_PERIOD_NS / 2);
  end

  // The run must not hang if the block stops answering.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("Verification failed");
    $finish;
  end

  // The receiver stalls at random, except during a long hold-off, which it
  // counts down itself while the sender keeps offering words.
  initial begin : receiver
    int unsigned hold_left;
    bit seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Loads worth having often: both extremes and small values of either sign.
  function automatic logic [DATA_W-1:0] pick_load();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return DATA_W'($urandom_range(15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Coalitions: empty, everyone, one or two agents, all but one, or random.
  function automatic logic [MASK_W-1:0] pick_members();
    logic [MASK_W-1:0] one;
    one = MASK_W'(1) << $urandom_range(MASK_W - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return one;
      3:       return one | (MASK_W'(1) << $urandom_range(MASK_W - 1));
      4:       return ~one;
      default: return MASK_W'($urandom());
    endcase
  endfunction

  // Packs one word, notes which table entry it fills, and offers it until the
  // block takes it. The sender may idle first, as the current phase says.
  task automatic send_item(
    input cgv_op_t              op,
    input logic [AGENT_W-1:0]   hi,
    input logic [AGENT_W-1:0]   lo,
    input logic [SLOT_W-1:0]    slot,
    input logic [DATA_W-1:0]    load,
    input logic [MASK_W-1:0]    members
  );
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[OP_LSB   +: OP_W]    = op;
    w[HI_LSB   +: AGENT_W] = hi;
    w[LO_LSB   +: AGENT_W] = lo;
    w[SLOT_LSB +: SLOT_W]  = slot;
    w[DATA_LSB +: DATA_W]  = load;
    w[MASK_LSB +: MASK_W]  = members;
    case (op)
      OP_WR_VALUE: begin
        if (hi < DEF_AGENTS) value_ok[hi] = 1'b1;
      end
      OP_WR_MAP: begin
        if (hi < DEF_AGENTS && lo < DEF_AGENTS) begin
          map_ok[hi*DEF_AGENTS + lo]   = 1'b1;
          map_slot[hi*DEF_AGENTS + lo] = slot;
        end
      end
      OP_WR_WEIGHT: begin
        if (slot < DEF_EDGE_SLOTS) weight_ok[slot] = 1'b1;
      end
      default: ;
    endcase
    words_sent++;
    words_by_op[op]++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Evaluates a coalition. Any value, pair map or weight that the walk would
  // read and that was never written is written first with random content.
  task automatic evaluate_coalition(input logic [MASK_W-1:0] members);
    int pair;
    for (int a = 0; a < DEF_AGENTS; a++) begin
      if (members[a]) begin
        if (!value_ok[a])
          send_item(OP_WR_VALUE, AGENT_W'(a), AGENT_W'($urandom), SLOT_W'($urandom),
                    pick_load(), MASK_W'($urandom));
        for (int b = 0; b < a; b++) begin
          if (members[b]) begin
            pair = a*DEF_AGENTS + b;
            if (!map_ok[pair])
              send_item(OP_WR_MAP, AGENT_W'(a), AGENT_W'(b), SLOT_W'($urandom), $urandom,
                        MASK_W'($urandom));
            if (map_slot[pair] < DEF_EDGE_SLOTS && !weight_ok[map_slot[pair]])
              send_item(OP_WR_WEIGHT, AGENT_W'($urandom), AGENT_W'($urandom),
                        map_slot[pair], pick_load(), MASK_W'($urandom));
          end
        end
      end
    end
    send_item(OP_EVAL, AGENT_W'($urandom), AGENT_W'($urandom), SLOT_W'($urandom),
              $urandom, members);
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 18)
      send_item(OP_WR_VALUE, AGENT_W'($urandom), AGENT_W'($urandom), SLOT_W'($urandom),
                pick_load(), MASK_W'($urandom));
    else if (pick < 36)
      send_item(OP_WR_MAP, AGENT_W'($urandom), AGENT_W'($urandom), SLOT_W'($urandom),
                $urandom, MASK_W'($urandom));
    else if (pick < 54)
      send_item(OP_WR_WEIGHT, AGENT_W'($urandom), AGENT_W'($urandom), SLOT_W'($urandom),
                pick_load(), MASK_W'($urandom));
    else
      evaluate_coalition(pick_members());
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    words_sent = 0;
    foreach (words_by_op[i]) words_by_op[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, back to back. The empty coalition reads nothing and
    // must give zero; then single agents at both ends of the value range and
    // one internal pair. The pair is also written reversed, lower agent
    // first, and that entry must never be read.
    evaluate_coalition('0);
    send_item(OP_WR_VALUE, 4'd0, 4'hF, '1, 32'h7FFF_FFFF, '1);
    evaluate_coalition(16'h0001);
    send_item(OP_WR_VALUE, 4'hF, 4'd0, '0, 32'h8000_0000, '0);
    send_item(OP_WR_MAP, 4'hF, 4'd0, 7'd127, '0, '0);
    send_item(OP_WR_MAP, 4'd0, 4'hF, 7'd5, '1, '1);
    send_item(OP_WR_WEIGHT, '0, '1, 7'd127, 32'h7FFF_FFFF, '0);
    evaluate_coalition(16'h8001);
    evaluate_coalition(16'h8000);

    // Largest and smallest totals: every agent in, every value and the one
    // shared pair weight at the top, then at the bottom of the range.
    for (int a = 0; a < DEF_AGENTS; a++)
      send_item(OP_WR_VALUE, AGENT_W'(a), AGENT_W'($urandom), SLOT_W'($urandom),
                32'h7FFF_FFFF, MASK_W'($urandom));
    for (int a = 1; a < DEF_AGENTS; a++)
      for (int b = 0; b < a; b++)
        send_item(OP_WR_MAP, AGENT_W'(a), AGENT_W'(b), '0, $urandom, MASK_W'($urandom));
    send_item(OP_WR_WEIGHT, AGENT_W'($urandom), AGENT_W'($urandom), '0, 32'h7FFF_FFFF,
              MASK_W'($urandom));
    evaluate_coalition('1);
    for (int a = 0; a < DEF_AGENTS; a++)
      send_item(OP_WR_VALUE, AGENT_W'(a), AGENT_W'($urandom), SLOT_W'($urandom),
                32'h8000_0000, MASK_W'($urandom));
    send_item(OP_WR_WEIGHT, AGENT_W'($urandom), AGENT_W'($urandom), '0, 32'h8000_0000,
              MASK_W'($urandom));
    evaluate_coalition('1);

    // Random words in four idle/stall mixes. After the first mix the
    // receiver holds off for a long stretch while evaluations keep coming,
    // so the output register fills and the block stops taking words.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_end = words_sent + RANDOM_WORDS / 4;
      while (words_sent < phase_end) random_item();
      if (phase == 0) begin
        hold_toggle <= ~hold_toggle;
        repeat (6) evaluate_coalition(pick_members());
      end
    end
    in_tvalid <= 1'b0;

    // Let everything still owed come out, then give the block time to finish
    // any work in flight.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d value, %0d pair map and %0d weight writes, %0d evaluations.",
             words_sent, words_by_op[OP_WR_VALUE], words_by_op[OP_WR_MAP],
             words_by_op[OP_WR_WEIGHT], words_by_op[OP_EVAL]);
    $display("Checked %0d coalition totals over four idle/stall mixes and one long hold-off.",
             totals_checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
